>>> sv/slacc_pkg.sv
package slacc_pkg;

   // default geometry and walk length
   localparam int ImgWidthDefault  = 480;
   localparam int ImgHeightDefault = 360;
   localparam int MaxStepsDefault  = 2048;

   // field and datapath widths
   localparam int COORD_W    = 19;   // Q10.8 signed coordinate
   localparam int DIFF_W     = 20;   // end minus start
   localparam int SQF_W      = 40;   // full square of a difference
   localparam int POS_W      = 21;   // walk point with cross offset
   localparam int SQ_W       = 39;   // sum of squares
   localparam int ROOT_W     = 20;   // segment length, Q.8
   localparam int SQRT_ITERS = 20;
   localparam int MAG_W      = 19;   // magnitude of a difference
   localparam int DIV_ITERS  = 19;
   localparam int ITER_W     = 5;
   localparam int XI_W       = 12;   // integer pixel part of a position
   localparam int ACC_W      = 24;   // Q8.16 accumulator channel
   localparam int AMT_W      = 16;   // splat amount per channel
   localparam int WGT_W      = 17;   // bilinear weight, Q0.16 up to 1.0
   localparam int PROD_W     = 17;
   localparam int CH_N       = 3;
   localparam int ROW_W      = ACC_W * CH_N;
   localparam int PIX_W      = 18;
   localparam int COL_W      = 8;
   localparam int GAIN_W     = 16;
   localparam int CSR_W      = 32;
   localparam int PADDR_W    = 3;

   localparam logic [15:0] DECAY_RESET = 16'd47186;  // 0.72
   localparam logic [15:0] K085        = 16'd55706;  // 0.85
   localparam logic [15:0] K030        = 16'd19661;  // 0.30
   localparam logic [15:0] RECIP255    = 16'd32897;  // 2^23 / 255, rounded up
   localparam logic signed [POS_W-1:0] CROSS_OFS = 21'sd410;  // 1.6 pixel

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_DECAY = 1'b0;

   // splat order around one walk point
   localparam logic [2:0] SPLAT_CORE  = 3'd0;
   localparam logic [2:0] SPLAT_LEFT  = 3'd1;
   localparam logic [2:0] SPLAT_RIGHT = 3'd2;
   localparam logic [2:0] SPLAT_UP    = 3'd3;
   localparam logic [2:0] SPLAT_DOWN  = 3'd4;

   // cells of one bilinear splat
   localparam logic [1:0] CELL_TL = 2'd0;
   localparam logic [1:0] CELL_TR = 2'd1;
   localparam logic [1:0] CELL_BL = 2'd2;
   localparam logic [1:0] CELL_BR = 2'd3;

   typedef struct packed {
      logic       load;
      logic       clear_wr;
      logic       sq_mul;
      logic       sq_add;
      logic       sqrt_step;
      logic       core_fix;
      logic       side_mul;
      logic       steps_calc;
      logic       div_step;
      logic       div_fix;
      logic       splat_pos;
      logic       splat_wgt;
      logic       cell_rd;
      logic       cell_wr;
      logic       advance;
      logic       tone_rd;
      logic       tone_wr;
      logic [2:0] splat_sel;
      logic [1:0] cell_sel;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic splat_hit;
      logic point_last;
   } status_type;

endpackage

>>> sv/slacc_ram.sv
module slacc_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/slacc_ctrl.sv
module slacc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_op,
   input  slacc_pkg::status_type  status,
   output slacc_pkg::cmd_type     cmd,
   output logic                   busy
);

   typedef enum logic [16:0] {
      ST_CLEAR    = 17'b00000000000000001,
      ST_IDLE     = 17'b00000000000000010,
      ST_TONE_RD  = 17'b00000000000000100,
      ST_TONE_WR  = 17'b00000000000001000,
      ST_SQ_MUL   = 17'b00000000000010000,
      ST_SQ_ADD   = 17'b00000000000100000,
      ST_SQRT     = 17'b00000000001000000,
      ST_CORE_FIX = 17'b00000000010000000,
      ST_SIDE_MUL = 17'b00000000100000000,
      ST_STEPS    = 17'b00000001000000000,
      ST_DIV      = 17'b00000010000000000,
      ST_DIV_FIX  = 17'b00000100000000000,
      ST_POS      = 17'b00001000000000000,
      ST_WGT      = 17'b00010000000000000,
      ST_CELL_RD  = 17'b00100000000000000,
      ST_CELL_WR  = 17'b01000000000000000,
      ST_ADVANCE  = 17'b10000000000000000
   } state_type;

   typedef logic [slacc_pkg::ITER_W-1:0] iter_type;

   state_type state_ff, state_in;
   iter_type iter_ff, iter_in;
   logic [2:0] splat_ff, splat_in;
   logic [1:0] cell_ff, cell_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         iter_ff  <= '0;
         splat_ff <= slacc_pkg::SPLAT_CORE;
         cell_ff  <= slacc_pkg::CELL_TL;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         splat_ff <= splat_in;
         cell_ff  <= cell_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      splat_in = splat_ff;
      cell_in  = cell_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = req_op ? ST_TONE_RD : ST_SQ_MUL;
         end
         ST_TONE_RD: state_in = ST_TONE_WR;
         ST_TONE_WR: state_in = ST_IDLE;
         ST_SQ_MUL:  state_in = ST_SQ_ADD;
         ST_SQ_ADD: begin
            iter_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == iter_type'(slacc_pkg::SQRT_ITERS - 1)) state_in = ST_CORE_FIX;
         end
         ST_CORE_FIX: state_in = ST_SIDE_MUL;
         ST_SIDE_MUL: state_in = ST_STEPS;
         ST_STEPS: begin
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            iter_in = iter_ff + 1'b1;
            if (iter_ff == iter_type'(slacc_pkg::DIV_ITERS - 1)) state_in = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            splat_in = slacc_pkg::SPLAT_CORE;
            state_in = ST_POS;
         end
         ST_POS: state_in = ST_WGT;
         ST_WGT: begin
            cell_in = slacc_pkg::CELL_TL;
            if (status.splat_hit) begin
               state_in = ST_CELL_RD;
            end else if (splat_ff == slacc_pkg::SPLAT_DOWN) begin
               state_in = ST_ADVANCE;
            end else begin
               splat_in = splat_ff + 3'd1;
               state_in = ST_POS;
            end
         end
         ST_CELL_RD: state_in = ST_CELL_WR;
         ST_CELL_WR: begin
            if (cell_ff != slacc_pkg::CELL_BR) begin
               cell_in  = cell_ff + 2'd1;
               state_in = ST_CELL_RD;
            end else if (splat_ff == slacc_pkg::SPLAT_DOWN) begin
               state_in = ST_ADVANCE;
            end else begin
               splat_in = splat_ff + 3'd1;
               state_in = ST_POS;
            end
         end
         ST_ADVANCE: begin
            splat_in = slacc_pkg::SPLAT_CORE;
            state_in = status.point_last ? ST_IDLE : ST_POS;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == ST_IDLE) && start;
      cmd.clear_wr   = (state_ff == ST_CLEAR);
      cmd.sq_mul     = (state_ff == ST_SQ_MUL);
      cmd.sq_add     = (state_ff == ST_SQ_ADD);
      cmd.sqrt_step  = (state_ff == ST_SQRT);
      cmd.core_fix   = (state_ff == ST_CORE_FIX);
      cmd.side_mul   = (state_ff == ST_SIDE_MUL);
      cmd.steps_calc = (state_ff == ST_STEPS);
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.div_fix    = (state_ff == ST_DIV_FIX);
      cmd.splat_pos  = (state_ff == ST_POS);
      cmd.splat_wgt  = (state_ff == ST_WGT);
      cmd.cell_rd    = (state_ff == ST_CELL_RD);
      cmd.cell_wr    = (state_ff == ST_CELL_WR);
      cmd.advance    = (state_ff == ST_ADVANCE);
      cmd.tone_rd    = (state_ff == ST_TONE_RD);
      cmd.tone_wr    = (state_ff == ST_TONE_WR);
      cmd.splat_sel  = splat_ff;
      cmd.cell_sel   = cell_ff;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> sv/slacc_dpath.sv
module slacc_dpath #(
   parameter int IMG_WIDTH  = slacc_pkg::ImgWidthDefault,
   parameter int IMG_HEIGHT = slacc_pkg::ImgHeightDefault,
   parameter int MAX_STEPS  = slacc_pkg::MaxStepsDefault,
   localparam int NPIX   = IMG_WIDTH * IMG_HEIGHT,
   localparam int ADDR_W = $clog2(NPIX),
   localparam int STEP_W = $clog2(MAX_STEPS + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  slacc_pkg::cmd_type                     cmd,
   output slacc_pkg::status_type                  status,
   input  logic signed [slacc_pkg::COORD_W-1:0]   req_x_start,
   input  logic signed [slacc_pkg::COORD_W-1:0]   req_y_start,
   input  logic signed [slacc_pkg::COORD_W-1:0]   req_x_end,
   input  logic signed [slacc_pkg::COORD_W-1:0]   req_y_end,
   input  logic [slacc_pkg::COL_W-1:0]            req_red_in,
   input  logic [slacc_pkg::COL_W-1:0]            req_green_in,
   input  logic [slacc_pkg::COL_W-1:0]            req_blue_in,
   input  logic [slacc_pkg::GAIN_W-1:0]           req_gain,
   input  logic [slacc_pkg::PIX_W-1:0]            req_pixel_index,
   input  logic [15:0]                            decay,
   output logic                                   mem_we,
   output logic [ADDR_W-1:0]                      mem_waddr,
   output logic [slacc_pkg::ROW_W-1:0]            mem_wdata,
   output logic [ADDR_W-1:0]                      mem_raddr,
   input  logic [slacc_pkg::ROW_W-1:0]            mem_rdata,
   output logic                                   rsp_valid,
   output logic [slacc_pkg::PIX_W-1:0]            rsp_pixel_out,
   output logic [slacc_pkg::COL_W-1:0]            rsp_red_out,
   output logic [slacc_pkg::COL_W-1:0]            rsp_green_out,
   output logic [slacc_pkg::COL_W-1:0]            rsp_blue_out
);

   localparam int CH   = slacc_pkg::CH_N;
   localparam int AW_  = slacc_pkg::ACC_W;
   localparam int DW   = slacc_pkg::DIFF_W;
   localparam int PW   = slacc_pkg::POS_W;
   localparam int SW   = slacc_pkg::SQ_W;
   localparam int MW   = slacc_pkg::MAG_W;
   localparam int XW   = slacc_pkg::XI_W;
   localparam int WW   = slacc_pkg::WGT_W;
   localparam int QW   = slacc_pkg::PROD_W;
   localparam int MTW  = slacc_pkg::AMT_W;

   // captured item
   logic signed [slacc_pkg::COORD_W-1:0] x0_ff, y0_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [slacc_pkg::COL_W-1:0] col_ff [CH];
   logic [slacc_pkg::GAIN_W-1:0] gain_ff;
   logic [slacc_pkg::PIX_W-1:0] pix_ff;
   logic pix_ok_ff;

   // length and amounts
   logic [SW-1:0] dx2_ff, dy2_ff, rem_ff, bit_ff;
   logic [SW:0] root_ff;
   logic [AW_-1:0] cg_ff [CH];
   logic [QW-1:0] qe_ff [CH];
   logic [MTW-1:0] core_ff [CH];
   logic [MTW-1:0] side_ff [CH];
   logic [STEP_W-1:0] steps_ff;

   // per-axis division and walk, lane 0 is x, lane 1 is y
   logic [MW-1:0] mag_ff [2];
   logic [MW-1:0] quo_ff [2];
   logic [STEP_W-1:0] rdv_ff [2];
   logic neg_ff [2];
   logic signed [DW-1:0] qd_ff [2];
   logic [STEP_W-1:0] rd_ff [2];
   logic signed [PW-1:0] pt_ff [2];
   logic [STEP_W-1:0] fr_ff [2];
   logic [STEP_W-1:0] k_ff;

   // splat
   logic [7:0] fx_ff, fy_ff;
   logic [XW-1:0] xi_ff, yi_ff;
   logic hit_ff, core_sel_ff;
   logic [WW-1:0] w_ff [4];
   logic [ADDR_W-1:0] base_ff, cell_addr_ff;
   logic [QW-1:0] prod_ff [CH];

   logic [ADDR_W-1:0] clear_addr_ff;
   logic rsp_valid_ff;
   logic [slacc_pkg::PIX_W-1:0] rsp_pixel_ff;
   logic [slacc_pkg::COL_W-1:0] rsp_col_ff [CH];

   // combinational helpers
   logic signed [slacc_pkg::SQF_W-1:0] dx_sq, dy_sq;
   logic [SW:0] trial;
   logic [35:0] len_prod;
   logic [12:0] steps_raw;
   logic signed [DW-1:0] dval [2];
   logic signed [PW-1:0] sx, sy;
   logic hit;
   logic [8:0] ifx, ify;
   logic [ADDR_W-1:0] cell_addr;
   logic [MTW-1:0] amt [CH];
   logic [AW_-1:0] rd_ch [CH];
   logic [AW_-1:0] sat_ch [CH];
   logic [AW_-1:0] dec_ch [CH];
   logic [slacc_pkg::COL_W-1:0] tone_ch [CH];

   assign dx_sq = slacc_pkg::SQF_W'(dx_ff) * slacc_pkg::SQF_W'(dx_ff);
   assign dy_sq = slacc_pkg::SQF_W'(dy_ff) * slacc_pkg::SQF_W'(dy_ff);
   assign trial = root_ff + (SW + 1)'(bit_ff);
   assign len_prod = 36'(root_ff[slacc_pkg::ROOT_W-1:0]) * 36'(slacc_pkg::K085);
   assign steps_raw = 13'(len_prod[35:24]) + 13'd1;
   assign dval[0] = dx_ff;
   assign dval[1] = dy_ff;

   // splat center for the selected neighbor
   always_comb begin
      sx = pt_ff[0];
      sy = pt_ff[1];
      case (cmd.splat_sel)
         slacc_pkg::SPLAT_CORE:  ;
         slacc_pkg::SPLAT_LEFT:  sx = pt_ff[0] - slacc_pkg::CROSS_OFS;
         slacc_pkg::SPLAT_RIGHT: sx = pt_ff[0] + slacc_pkg::CROSS_OFS;
         slacc_pkg::SPLAT_UP:    sy = pt_ff[1] - slacc_pkg::CROSS_OFS;
         slacc_pkg::SPLAT_DOWN:  sy = pt_ff[1] + slacc_pkg::CROSS_OFS;
         default: ;
      endcase
      hit = !sx[PW-1] && !sy[PW-1]
         && (32'(sx[XW+7:8]) < 32'(IMG_WIDTH - 1))
         && (32'(sy[XW+7:8]) < 32'(IMG_HEIGHT - 1));
   end

   assign ifx = 9'd256 - 9'(fx_ff);
   assign ify = 9'd256 - 9'(fy_ff);

   always_comb begin
      case (cmd.cell_sel)
         slacc_pkg::CELL_TL: cell_addr = base_ff;
         slacc_pkg::CELL_TR: cell_addr = base_ff + ADDR_W'(1);
         slacc_pkg::CELL_BL: cell_addr = base_ff + ADDR_W'(IMG_WIDTH);
         slacc_pkg::CELL_BR: cell_addr = base_ff + ADDR_W'(IMG_WIDTH + 1);
         default:            cell_addr = base_ff;
      endcase
   end

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         logic [AW_:0] sum;
         logic [31:0] tfull;
         logic [AW_+15:0] dfull;
         amt[c]   = core_sel_ff ? core_ff[c] : side_ff[c];
         rd_ch[c] = mem_rdata[c*AW_ +: AW_];
         sum      = (AW_ + 1)'(rd_ch[c]) + (AW_ + 1)'(prod_ff[c]);
         sat_ch[c] = sum[AW_] ? {AW_{1'b1}} : sum[AW_-1:0];
         tfull    = (32'(rd_ch[c]) * 32'd255) >> 16;
         tone_ch[c] = (tfull > 32'd255) ? 8'd255 : tfull[7:0];
         dfull    = (AW_ + 16)'(rd_ch[c]) * (AW_ + 16)'(decay);
         dec_ch[c] = dfull[AW_+15:16];
      end
   end

   // memory ports
   always_comb begin
      mem_raddr = cmd.tone_rd ? ADDR_W'(pix_ff) : cell_addr;
      mem_we    = cmd.clear_wr || cmd.cell_wr || (cmd.tone_wr && pix_ok_ff);
      if (cmd.clear_wr) begin
         mem_waddr = clear_addr_ff;
      end else if (cmd.cell_wr) begin
         mem_waddr = cell_addr_ff;
      end else begin
         mem_waddr = ADDR_W'(pix_ff);
      end
      for (int c = 0; c < CH; c++) begin
         if (cmd.clear_wr) begin
            mem_wdata[c*AW_ +: AW_] = '0;
         end else if (cmd.cell_wr) begin
            mem_wdata[c*AW_ +: AW_] = sat_ch[c];
         end else begin
            mem_wdata[c*AW_ +: AW_] = dec_ch[c];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear_wr) clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         rsp_valid_ff <= cmd.tone_wr;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff   <= req_x_start;
         y0_ff   <= req_y_start;
         dx_ff   <= DW'(req_x_end) - DW'(req_x_start);
         dy_ff   <= DW'(req_y_end) - DW'(req_y_start);
         col_ff[0] <= req_red_in;
         col_ff[1] <= req_green_in;
         col_ff[2] <= req_blue_in;
         gain_ff <= req_gain;
         pix_ff  <= req_pixel_index;
         pix_ok_ff <= (32'(req_pixel_index) < 32'(NPIX));
      end

      if (cmd.sq_mul) begin
         dx2_ff <= dx_sq[SW-1:0];
         dy2_ff <= dy_sq[SW-1:0];
         for (int c = 0; c < CH; c++) begin
            cg_ff[c] <= AW_'(col_ff[c]) * AW_'(gain_ff);
         end
      end

      if (cmd.sq_add) begin
         rem_ff  <= dx2_ff + dy2_ff;
         root_ff <= '0;
         bit_ff  <= SW'(1) << (SW - 1);
         for (int c = 0; c < CH; c++) begin
            logic [39:0] qprod;
            qprod = 40'(cg_ff[c]) * 40'(slacc_pkg::RECIP255);
            qe_ff[c] <= qprod[39:23];
         end
      end

      // one root bit per step
      if (cmd.sqrt_step) begin
         if ((SW + 1)'(rem_ff) >= trial) begin
            rem_ff  <= rem_ff - SW'(trial);
            root_ff <= (root_ff >> 1) + (SW + 1)'(bit_ff);
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end

      // drop the reciprocal estimate by one where it overshoots
      if (cmd.core_fix) begin
         for (int c = 0; c < CH; c++) begin
            logic [AW_:0] chk;
            chk = {qe_ff[c], 8'd0} - (AW_ + 1)'(qe_ff[c]);
            core_ff[c] <= (chk > (AW_ + 1)'(cg_ff[c])) ? MTW'(qe_ff[c] - QW'(1))
                                                       : MTW'(qe_ff[c]);
         end
      end

      if (cmd.side_mul) begin
         for (int c = 0; c < CH; c++) begin
            logic [31:0] sp;
            sp = 32'(core_ff[c]) * 32'(slacc_pkg::K030);
            side_ff[c] <= sp[31:16];
         end
      end

      if (cmd.steps_calc) begin
         steps_ff <= (32'(steps_raw) > 32'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                      : STEP_W'(steps_raw);
         for (int l = 0; l < 2; l++) begin
            logic [DW-1:0] mag;
            mag = dval[l][DW-1] ? DW'(-dval[l]) : DW'(dval[l]);
            mag_ff[l] <= mag[MW-1:0];
            neg_ff[l] <= dval[l][DW-1];
            quo_ff[l] <= '0;
            rdv_ff[l] <= '0;
         end
      end

      // restoring division, one quotient bit per step in each lane
      if (cmd.div_step) begin
         for (int l = 0; l < 2; l++) begin
            logic [STEP_W:0] rr;
            rr = {rdv_ff[l], mag_ff[l][MW-1]};
            if (rr >= (STEP_W + 1)'(steps_ff)) begin
               rdv_ff[l] <= STEP_W'(rr - (STEP_W + 1)'(steps_ff));
               quo_ff[l] <= {quo_ff[l][MW-2:0], 1'b1};
            end else begin
               rdv_ff[l] <= rr[STEP_W-1:0];
               quo_ff[l] <= {quo_ff[l][MW-2:0], 1'b0};
            end
            mag_ff[l] <= mag_ff[l] << 1;
         end
      end

      // turn truncated quotient into floor quotient and walk start
      if (cmd.div_fix) begin
         for (int l = 0; l < 2; l++) begin
            logic signed [DW-1:0] qpos;
            qpos = signed'(DW'(quo_ff[l]));
            if (neg_ff[l] && (rdv_ff[l] != '0)) begin
               qd_ff[l] <= -qpos - DW'(1);
               rd_ff[l] <= steps_ff - rdv_ff[l];
            end else if (neg_ff[l]) begin
               qd_ff[l] <= -qpos;
               rd_ff[l] <= '0;
            end else begin
               qd_ff[l] <= qpos;
               rd_ff[l] <= rdv_ff[l];
            end
            fr_ff[l] <= '0;
         end
         pt_ff[0] <= PW'(x0_ff);
         pt_ff[1] <= PW'(y0_ff);
         k_ff     <= '0;
      end

      if (cmd.advance) begin
         for (int l = 0; l < 2; l++) begin
            logic [STEP_W:0] fsum;
            logic carry;
            fsum  = (STEP_W + 1)'(fr_ff[l]) + (STEP_W + 1)'(rd_ff[l]);
            carry = (fsum >= (STEP_W + 1)'(steps_ff));
            fr_ff[l] <= carry ? STEP_W'(fsum - (STEP_W + 1)'(steps_ff)) : STEP_W'(fsum);
            pt_ff[l] <= pt_ff[l] + PW'(qd_ff[l]) + PW'(carry);
         end
         k_ff <= k_ff + STEP_W'(1);
      end

      if (cmd.splat_pos) begin
         fx_ff <= sx[7:0];
         fy_ff <= sy[7:0];
         xi_ff <= sx[XW+7:8];
         yi_ff <= sy[XW+7:8];
         hit_ff <= hit;
         core_sel_ff <= (cmd.splat_sel == slacc_pkg::SPLAT_CORE);
      end

      if (cmd.splat_wgt) begin
         w_ff[0] <= WW'(ifx) * WW'(ify);
         w_ff[1] <= WW'(fx_ff) * WW'(ify);
         w_ff[2] <= WW'(ifx) * WW'(fy_ff);
         w_ff[3] <= WW'(fx_ff) * WW'(fy_ff);
         base_ff <= ADDR_W'(yi_ff) * ADDR_W'(IMG_WIDTH) + ADDR_W'(xi_ff);
      end

      if (cmd.cell_rd) begin
         cell_addr_ff <= cell_addr;
         for (int c = 0; c < CH; c++) begin
            logic [32:0] pfull;
            pfull = 33'(amt[c]) * 33'(w_ff[cmd.cell_sel]);
            prod_ff[c] <= pfull[32:16];
         end
      end

      if (cmd.tone_wr) begin
         rsp_pixel_ff <= pix_ff;
         for (int c = 0; c < CH; c++) begin
            rsp_col_ff[c] <= pix_ok_ff ? tone_ch[c] : '0;
         end
      end
   end

   assign status.clear_last = (clear_addr_ff == ADDR_W'(NPIX - 1));
   assign status.splat_hit  = hit_ff;
   assign status.point_last = (k_ff == steps_ff - STEP_W'(1));

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_red_out   = rsp_col_ff[0];
   assign rsp_green_out = rsp_col_ff[1];
   assign rsp_blue_out  = rsp_col_ff[2];

endmodule

>>> sv/splat_line_accumulator.sv
// Channel   Direction  Handshake                   Word
// req_*     in         start high while busy low   op, segment, colour, gain, pixel
// rsp_*     out        rsp_valid, one cycle        pixel index and tone-mapped RGB
// csr       in/out     psel, penable, pwrite       decay_factor at byte address 0
//
// Tone item: read then write state after accept; busy drops as rsp_valid rises.
// Draw item: setup runs a 20-step square root and a 19-step divider; then each
// walk point takes position and weight states per splat, a read and a write per
// cell for each splat on the store, and one advance state; up to MAX_STEPS points.
// The accumulator RAM (one read port, one write port, registered read) sets this.
// After reset a clearing pass writes IMG_WIDTH*IMG_HEIGHT rows, one per cycle,
// with busy high.
// Results cannot be stalled: rsp_valid marks each word for exactly one cycle.
module splat_line_accumulator #(
   parameter int IMG_WIDTH  = slacc_pkg::ImgWidthDefault,
   parameter int IMG_HEIGHT = slacc_pkg::ImgHeightDefault,
   parameter int MAX_STEPS  = slacc_pkg::MaxStepsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_op,
   input  logic signed [slacc_pkg::COORD_W-1:0] req_x_start,
   input  logic signed [slacc_pkg::COORD_W-1:0] req_y_start,
   input  logic signed [slacc_pkg::COORD_W-1:0] req_x_end,
   input  logic signed [slacc_pkg::COORD_W-1:0] req_y_end,
   input  logic [slacc_pkg::COL_W-1:0]          req_red_in,
   input  logic [slacc_pkg::COL_W-1:0]          req_green_in,
   input  logic [slacc_pkg::COL_W-1:0]          req_blue_in,
   input  logic [slacc_pkg::GAIN_W-1:0]         req_gain,
   input  logic [slacc_pkg::PIX_W-1:0]          req_pixel_index,
   output logic                                 rsp_valid,
   output logic [slacc_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic [slacc_pkg::COL_W-1:0]          rsp_red_out,
   output logic [slacc_pkg::COL_W-1:0]          rsp_green_out,
   output logic [slacc_pkg::COL_W-1:0]          rsp_blue_out,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [slacc_pkg::PADDR_W-1:0]        paddr,
   input  logic [slacc_pkg::CSR_W-1:0]          pwdata,
   output logic [slacc_pkg::CSR_W-1:0]          prdata,
   output logic                                 pready
);

   localparam int NPIX   = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W = $clog2(NPIX);

   slacc_pkg::cmd_type    cmd;
   slacc_pkg::status_type status;

   logic [15:0] decay_ff;
   logic csr_wr;

   logic                          mem_we;
   logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
   logic [slacc_pkg::ROW_W-1:0]   mem_wdata, mem_rdata;

   // register file: one 16-bit decay multiplier, wait-free access
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= slacc_pkg::DECAY_RESET;
      end else if (csr_wr && (paddr[2] == slacc_pkg::CSR_IDX_DECAY)) begin
         decay_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr[2] == slacc_pkg::CSR_IDX_DECAY) ? 32'(decay_ff) : '0;

   // sequencer: clear pass, tone read-modify-write, draw walk
   slacc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // arithmetic, walk state, splat weights and tone mapping
   slacc_dpath #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT),
      .MAX_STEPS  (MAX_STEPS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_gain        (req_gain),
      .req_pixel_index (req_pixel_index),
      .decay           (decay_ff),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out)
   );

   // accumulator store: one row of three Q8.16 channels per pixel
   slacc_ram #(
      .WIDTH (slacc_pkg::ROW_W),
      .DEPTH (NPIX)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

`ifndef ASSERT_OFF
   // idle means the store is left alone
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !mem_we) else $error("accumulator written while idle");

   // every write lands inside the store
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < 32'(NPIX))) else $error("write outside store");

   // a tone item answers with rsp_valid once its read and write states are through
   a_tone_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op) |-> ##3 rsp_valid) else $error("tone result missing");

   // results never come back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
`endif

endmodule
